// ===== rtl/psvp_pkg.sv =====
`timescale 1ns / 1ps
package psvp_pkg;

  localparam int XY_W    = 34;
  localparam int Z_W     = 34;
  localparam int ACC_W   = 46;
  localparam int COORD_W = 40;
  localparam int HALF_W  = 20;
  localparam int DIR_W   = 32;
  localparam int VIS_W   = 32;
  localparam int RND_W   = 28;
  localparam int SUM_W   = 34;
  localparam int ADDR_W  = 4;
  localparam int DATA_W  = 32;
  localparam int ANG_W   = 32;

  localparam logic signed [XY_W-1:0]  GAIN_Q30    = 34'sd652032874;
  localparam logic signed [XY_W-1:0]  ROUND_BIAS  = 34'sd32;
  localparam int                      ROUND_SHIFT = 6;
  localparam logic signed [SUM_W-1:0] VIS_MAX     = 34'sd2147483647;
  localparam logic signed [SUM_W-1:0] VIS_MIN     = -34'sd2147483648;

  typedef enum logic [1:0] {
    REG_DIR_L = 2'd0,
    REG_DIR_M = 2'd1,
    REG_DIR_N = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic [VIS_W-1:0] vis_re;
    logic [VIS_W-1:0] vis_im;
    logic             last;
    logic             flip;
  } side_t;

  function automatic logic [ANG_W-1:0] atan_turn(input logic [4:0] idx);
    logic [ANG_W-1:0] r;
    case (idx)
      5'd0:    r = 32'h20000000;
      5'd1:    r = 32'h12E4051E;
      5'd2:    r = 32'h09FB385B;
      5'd3:    r = 32'h051111D4;
      5'd4:    r = 32'h028B0D43;
      5'd5:    r = 32'h0145D7E1;
      5'd6:    r = 32'h00A2F61E;
      5'd7:    r = 32'h00517C55;
      5'd8:    r = 32'h0028BE53;
      5'd9:    r = 32'h00145F2F;
      5'd10:   r = 32'h000A2F98;
      5'd11:   r = 32'h000517CC;
      5'd12:   r = 32'h00028BE6;
      5'd13:   r = 32'h000145F3;
      5'd14:   r = 32'h0000A2FA;
      5'd15:   r = 32'h0000517D;
      5'd16:   r = 32'h000028BE;
      5'd17:   r = 32'h0000145F;
      5'd18:   r = 32'h00000A30;
      5'd19:   r = 32'h00000518;
      5'd20:   r = 32'h0000028C;
      5'd21:   r = 32'h00000146;
      5'd22:   r = 32'h000000A3;
      5'd23:   r = 32'h00000051;
      5'd24:   r = 32'h00000029;
      5'd25:   r = 32'h00000014;
      5'd26:   r = 32'h0000000A;
      5'd27:   r = 32'h00000005;
      5'd28:   r = 32'h00000003;
      5'd29:   r = 32'h00000001;
      5'd30:   r = 32'h00000001;
      default: r = 32'h00000000;
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/psvp_phase.sv =====
`timescale 1ns / 1ps
module psvp_phase #(
  parameter int PHASE_BITS = 24
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          valid_in,
  input  logic [psvp_pkg::COORD_W-1:0]  u_coord,
  input  logic [psvp_pkg::COORD_W-1:0]  v_coord,
  input  logic [psvp_pkg::COORD_W-1:0]  w_coord,
  input  logic [psvp_pkg::DIR_W-1:0]    dir_l,
  input  logic [psvp_pkg::DIR_W-1:0]    dir_m,
  input  logic [psvp_pkg::DIR_W-1:0]    dir_n,
  input  psvp_pkg::side_t               side_in,
  output logic                          valid_out,
  output logic [psvp_pkg::Z_W-1:0]      z_out,
  output psvp_pkg::side_t               side_out
);
  import psvp_pkg::*;

  localparam int PH_W = ACC_W - HALF_W;

  logic [COORD_W-1:0] coord [3];
  logic [DIR_W-1:0]   dir   [3];

  logic signed [HALF_W+DIR_W:0]   prod_lo [3];
  logic signed [HALF_W+DIR_W-1:0] prod_hi [3];

  logic [ACC_W-1:0] pp_lo [3];
  logic [PH_W-1:0]  pp_hi [3];
  logic [ACC_W-1:0] term  [3];
  logic [ACC_W-1:0] acc;
  logic [PHASE_BITS-1:0] ang;
  logic             v1, v2, v3;
  side_t            side1, side2, side3;

  logic             flip;
  logic [ANG_W-1:0] ang_turn;

  assign coord[0] = u_coord;
  assign coord[1] = v_coord;
  assign coord[2] = w_coord;
  assign dir[0]   = dir_l;
  assign dir[1]   = dir_m;
  assign dir[2]   = dir_n;

  // coordinate split into unsigned low half and signed high half
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      prod_lo[k] = $signed({1'b0, coord[k][HALF_W-1:0]}) * $signed(dir[k]);
      prod_hi[k] = $signed(coord[k][COORD_W-1:HALF_W]) * $signed(dir[k]);
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      pp_lo[k] <= prod_lo[k][ACC_W-1:0];
      pp_hi[k] <= prod_hi[k][PH_W-1:0];
      term[k]  <= pp_lo[k] + {pp_hi[k], {HALF_W{1'b0}}};
    end
    acc   <= term[0] + term[1] + term[2];
    side1 <= side_in;
    side2 <= side1;
    side3 <= side2;
  end

  assign ang = acc[ACC_W-1 -: PHASE_BITS];

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      v1 <= valid_in;
      v2 <= v1;
      v3 <= v2;
    end
  end

  // second and third quadrant: add half a turn, negate the result later
  always_comb begin
    flip     = ang[PHASE_BITS-1] ^ ang[PHASE_BITS-2];
    ang_turn = ANG_W'(ang) << (ANG_W - PHASE_BITS);
    ang_turn[ANG_W-1] = ang_turn[ANG_W-1] ^ flip;
  end

  assign valid_out = v3;
  assign z_out     = Z_W'($signed(ang_turn));

  always_comb begin
    side_out      = side3;
    side_out.flip = flip;
  end

endmodule

// ===== rtl/psvp_cordic_stage.sv =====
`timescale 1ns / 1ps
module psvp_cordic_stage #(
  parameter int SHIFT = 0
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      valid_in,
  input  logic [psvp_pkg::XY_W-1:0] x_in,
  input  logic [psvp_pkg::XY_W-1:0] y_in,
  input  logic [psvp_pkg::Z_W-1:0]  z_in,
  input  psvp_pkg::side_t           side_in,
  output logic                      valid_out,
  output logic [psvp_pkg::XY_W-1:0] x_out,
  output logic [psvp_pkg::XY_W-1:0] y_out,
  output logic [psvp_pkg::Z_W-1:0]  z_out,
  output psvp_pkg::side_t           side_out
);
  import psvp_pkg::*;

  logic signed [XY_W-1:0] dx, dy;
  logic signed [Z_W-1:0]  da;
  logic [XY_W-1:0]        x_next, y_next;
  logic [Z_W-1:0]         z_next;

  always_comb begin
    dx = $signed(y_in) >>> SHIFT;
    dy = $signed(x_in) >>> SHIFT;
    da = $signed({{(Z_W-ANG_W){1'b0}}, atan_turn(5'(SHIFT))});
    if (!z_in[Z_W-1]) begin
      x_next = x_in - dx;
      y_next = y_in + dy;
      z_next = z_in - da;
    end else begin
      x_next = x_in + dx;
      y_next = y_in - dy;
      z_next = z_in + da;
    end
  end

  always_ff @(posedge clk) begin
    x_out    <= x_next;
    y_out    <= y_next;
    z_out    <= z_next;
    side_out <= side_in;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_out <= 1'b0;
    end else begin
      valid_out <= valid_in;
    end
  end

endmodule

// ===== rtl/psvp_out.sv =====
`timescale 1ns / 1ps
module psvp_out (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       valid_in,
  input  logic [psvp_pkg::XY_W-1:0]  x_in,
  input  logic [psvp_pkg::XY_W-1:0]  y_in,
  input  psvp_pkg::side_t            side_in,
  output logic                       done,
  output logic [psvp_pkg::VIS_W-1:0] vis_out_re,
  output logic [psvp_pkg::VIS_W-1:0] vis_out_im,
  output logic                       saturated,
  output logic                       last_out
);
  import psvp_pkg::*;

  logic signed [XY_W-1:0]  xn, yn, xr, yr;
  logic [RND_W-1:0]        cos_q, sin_q;
  side_t                   side_a;
  logic                    valid_a;
  logic signed [SUM_W-1:0] sum_re, sum_im;
  logic [VIS_W-1:0]        re_next, im_next;
  logic                    clip_re, clip_im;

  always_comb begin
    xn = side_in.flip ? -$signed(x_in) : $signed(x_in);
    yn = side_in.flip ? -$signed(y_in) : $signed(y_in);
    xr = (xn + ROUND_BIAS) >>> ROUND_SHIFT;
    yr = (yn + ROUND_BIAS) >>> ROUND_SHIFT;
  end

  always_ff @(posedge clk) begin
    cos_q  <= xr[RND_W-1:0];
    sin_q  <= yr[RND_W-1:0];
    side_a <= side_in;
  end

  always_comb begin
    sum_re  = SUM_W'($signed(side_a.vis_re)) + SUM_W'($signed(cos_q));
    sum_im  = SUM_W'($signed(side_a.vis_im)) - SUM_W'($signed(sin_q));
    clip_re = (sum_re > VIS_MAX) || (sum_re < VIS_MIN);
    clip_im = (sum_im > VIS_MAX) || (sum_im < VIS_MIN);
    if (sum_re > VIS_MAX) begin
      re_next = VIS_MAX[VIS_W-1:0];
    end else if (sum_re < VIS_MIN) begin
      re_next = VIS_MIN[VIS_W-1:0];
    end else begin
      re_next = sum_re[VIS_W-1:0];
    end
    if (sum_im > VIS_MAX) begin
      im_next = VIS_MAX[VIS_W-1:0];
    end else if (sum_im < VIS_MIN) begin
      im_next = VIS_MIN[VIS_W-1:0];
    end else begin
      im_next = sum_im[VIS_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    vis_out_re <= re_next;
    vis_out_im <= im_next;
    saturated  <= clip_re | clip_im;
    last_out   <= side_a.last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_a <= 1'b0;
      done    <= 1'b0;
    end else begin
      valid_a <= valid_in;
      done    <= valid_a;
    end
  end

endmodule

// ===== rtl/point_source_visibility_predict.sv =====
`timescale 1ns / 1ps
// Point-source visibility predictor. One sample is taken on every clock
// cycle (busy is always low) and its result appears on done after passing
// through the split multiply and phase sum, one register per CORDIC rotation
// stage, and the rounding and saturating accumulation. Results are shown for
// a single cycle and are not held, so the receiver must take every result on
// its done strobe. The user must write the direction registers over the APB
// port only while no sample is in flight; the block does not enforce this.
module point_source_visibility_predict #(
  parameter int CORDIC_STAGES = 20,
  parameter int PHASE_BITS    = 24
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  logic [psvp_pkg::COORD_W-1:0] u_coord,
  input  logic [psvp_pkg::COORD_W-1:0] v_coord,
  input  logic [psvp_pkg::COORD_W-1:0] w_coord,
  input  logic [psvp_pkg::VIS_W-1:0] vis_in_re,
  input  logic [psvp_pkg::VIS_W-1:0] vis_in_im,
  input  logic                       last_in,
  output logic                       done,
  output logic [psvp_pkg::VIS_W-1:0] vis_out_re,
  output logic [psvp_pkg::VIS_W-1:0] vis_out_im,
  output logic                       saturated,
  output logic                       last_out,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [psvp_pkg::ADDR_W-1:0] paddr,
  input  logic [psvp_pkg::DATA_W-1:0] pwdata,
  output logic [psvp_pkg::DATA_W-1:0] prdata,
  output logic                       pready
);
  import psvp_pkg::*;

  logic [DIR_W-1:0] dir_l, dir_m, dir_n;
  logic             cfg_wr;
  reg_idx_t         cfg_idx;
  side_t            side_in;

  logic             valid_c [CORDIC_STAGES+1];
  logic [XY_W-1:0]  x_c     [CORDIC_STAGES+1];
  logic [XY_W-1:0]  y_c     [CORDIC_STAGES+1];
  logic [Z_W-1:0]   z_c     [CORDIC_STAGES+1];
  side_t            side_c  [CORDIC_STAGES+1];

  assign busy    = 1'b0;
  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite;
  assign cfg_idx = reg_idx_t'(paddr[ADDR_W-1:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      dir_l <= '0;
      dir_m <= '0;
      dir_n <= '0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_DIR_L: dir_l <= pwdata;
        REG_DIR_M: dir_m <= pwdata;
        REG_DIR_N: dir_n <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_DIR_L: prdata = dir_l;
      REG_DIR_M: prdata = dir_m;
      REG_DIR_N: prdata = dir_n;
      default:   prdata = '0;
    endcase
  end

  always_comb begin
    side_in.vis_re = vis_in_re;
    side_in.vis_im = vis_in_im;
    side_in.last   = last_in;
    side_in.flip   = 1'b0;
  end

  psvp_phase #(
    .PHASE_BITS(PHASE_BITS)
  ) u_phase (
    .clk      (clk),
    .rst      (rst),
    .valid_in (start & ~busy),
    .u_coord  (u_coord),
    .v_coord  (v_coord),
    .w_coord  (w_coord),
    .dir_l    (dir_l),
    .dir_m    (dir_m),
    .dir_n    (dir_n),
    .side_in  (side_in),
    .valid_out(valid_c[0]),
    .z_out    (z_c[0]),
    .side_out (side_c[0])
  );

  assign x_c[0] = GAIN_Q30;
  assign y_c[0] = '0;

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_stage
    psvp_cordic_stage #(
      .SHIFT(i)
    ) u_stage (
      .clk      (clk),
      .rst      (rst),
      .valid_in (valid_c[i]),
      .x_in     (x_c[i]),
      .y_in     (y_c[i]),
      .z_in     (z_c[i]),
      .side_in  (side_c[i]),
      .valid_out(valid_c[i+1]),
      .x_out    (x_c[i+1]),
      .y_out    (y_c[i+1]),
      .z_out    (z_c[i+1]),
      .side_out (side_c[i+1])
    );
  end

  psvp_out u_out (
    .clk       (clk),
    .rst       (rst),
    .valid_in  (valid_c[CORDIC_STAGES]),
    .x_in      (x_c[CORDIC_STAGES]),
    .y_in      (y_c[CORDIC_STAGES]),
    .side_in   (side_c[CORDIC_STAGES]),
    .done      (done),
    .vis_out_re(vis_out_re),
    .vis_out_im(vis_out_im),
    .saturated (saturated),
    .last_out  (last_out)
  );

endmodule

// ===== rtl/psvp_checker.sv =====
`timescale 1ns / 1ps
module psvp_checker #(
  parameter int LATENCY = 25
) (
  input logic                       clk,
  input logic                       rst,
  input logic                       start,
  input logic                       busy,
  input logic                       last_in,
  input logic                       done,
  input logic [psvp_pkg::VIS_W-1:0] vis_out_re,
  input logic [psvp_pkg::VIS_W-1:0] vis_out_im,
  input logic                       saturated,
  input logic                       last_out
);
  import psvp_pkg::*;

  localparam logic [VIS_W-1:0] RAIL_HI = VIS_MAX[VIS_W-1:0];
  localparam logic [VIS_W-1:0] RAIL_LO = VIS_MIN[VIS_W-1:0];

  a_never_busy: assert property (@(posedge clk) disable iff (rst) !busy)
    else $error("busy raised");

  a_transfer_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##LATENCY done)
    else $error("accepted sample gave no result");

  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, LATENCY))
    else $error("result with no accepted sample");

  a_last_follows: assert property (@(posedge clk) disable iff (rst)
    done |-> (last_out == $past(last_in, LATENCY)))
    else $error("last flag out of step");

  a_sat_on_rail: assert property (@(posedge clk) disable iff (rst)
    (done && saturated) |-> (vis_out_re == RAIL_HI || vis_out_re == RAIL_LO ||
                             vis_out_im == RAIL_HI || vis_out_im == RAIL_LO))
    else $error("saturated with no clipped part");

endmodule

bind point_source_visibility_predict psvp_checker #(
  .LATENCY(CORDIC_STAGES + 5)
) u_checker (
  .clk       (clk),
  .rst       (rst),
  .start     (start),
  .busy      (busy),
  .last_in   (last_in),
  .done      (done),
  .vis_out_re(vis_out_re),
  .vis_out_im(vis_out_im),
  .saturated (saturated),
  .last_out  (last_out)
);
